/* hw/rtl/mrt_pkg.sv */
// Shared constants and types for the memory region table.
`default_nettype none

package mrt_pkg;

	// Table size and derived widths
	localparam int MAX_REGIONS = 32;
	localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CNT_W = $clog2(MAX_REGIONS + 1);

	// Field widths
	localparam int ADDR_W = 64;
	localparam int END_W = ADDR_W + 1;
	localparam int KIND_W = 32;
	localparam int QRY_W = 32;
	localparam int QEND_W = QRY_W + 1;
	localparam int IN_DATA_W = 224;
	localparam int OUT_DATA_W = 40;

	// Region kind that gets stored
	localparam logic [KIND_W-1:0] KIND_USABLE = 32'd1;

	// Item modes carried on the input tuser
	localparam logic MODE_ADD = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Outcome of checking one stored region against a query
	typedef struct packed {
		logic             in_lo;  // region base at or below the address
		logic             fit;    // query end at or below region end
		logic             covers; // address at or below region end
		logic [QRY_W-1:0] space;  // bytes to region end, saturated
	} match_t;

endpackage

`default_nettype wire

/* hw/rtl/mrt_match.sv */
// Compare unit: checks one stored region against the current query.
`default_nettype none

module mrt_match (
	input  wire logic [mrt_pkg::ADDR_W-1:0] base,
	input  wire logic [mrt_pkg::END_W-1:0]  region_end,
	input  wire logic [mrt_pkg::QRY_W-1:0]  addr,
	input  wire logic [mrt_pkg::QEND_W-1:0] qend,
	output mrt_pkg::match_t                 result
);

	logic [mrt_pkg::END_W-1:0] rem;

	// Distance from the address to the inclusive region end
	assign rem = region_end - {{(mrt_pkg::END_W - mrt_pkg::QRY_W){1'b0}}, addr};

	always_comb begin
		result.in_lo  = base <= {{(mrt_pkg::ADDR_W - mrt_pkg::QRY_W){1'b0}}, addr};
		result.fit    = {{(mrt_pkg::END_W - mrt_pkg::QEND_W){1'b0}}, qend} <= region_end;
		result.covers = {{(mrt_pkg::END_W - mrt_pkg::QRY_W){1'b0}}, addr} <= region_end;
		// Saturate the remaining space to the result width
		if (|rem[mrt_pkg::END_W-1:mrt_pkg::QRY_W]) begin
			result.space = '1;
		end else begin
			result.space = rem[mrt_pkg::QRY_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/memory_region_table_unit.sv */
// Top level of the memory region table: region store, scan sequencer, output register.
//
// Input channel s_axis: one word per item. tuser carries the mode (add or query),
// tdata carries region base, length and kind and the query address and size.
// Output channel m_axis: exactly one result word per input word, in order:
// range_fits, space_left and add_dropped.
// An add of a usable region writes it (base and precomputed 65-bit end) into the
// store in the cycle it is accepted, unless the table is full; its result word
// passes through the emit state into the output register.
// A query walks the stored regions one per cycle through the store's registered read
// port, then its result word passes through the emit state into the output register.
// One item is in work at a time; s_axis_tready is high whenever the sequencer is
// idle, which it returns to as a result is loaded into the output register.
// The result sits in an output register, so a new item is taken while it waits;
// when the receiver stalls and a second result is finished, the sequencer holds
// that result and takes no further item until the output register frees up.
// Reset empties the table (entry count to zero) and drops any pending result;
// the region store itself is not cleared, only entries below the count are read.
`default_nettype none

module memory_region_table_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// [63:0] region_base, [127:64] region_length, [159:128] region_kind,
	// [191:160] query_addr, [223:192] query_size
	input  wire logic [mrt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// [0] mode
	input  wire logic                            s_axis_tuser,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [0] range_fits, [32:1] space_left, [33] add_dropped, [39:34] zero
	output logic [mrt_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t state_q;

	// Input word fields
	logic [mrt_pkg::ADDR_W-1:0] in_base;
	logic [mrt_pkg::ADDR_W-1:0] in_length;
	logic [mrt_pkg::KIND_W-1:0] in_kind;
	logic [mrt_pkg::QRY_W-1:0]  in_addr;
	logic [mrt_pkg::QRY_W-1:0]  in_size;
	logic [mrt_pkg::END_W-1:0]  in_end;

	assign in_base   = s_axis_tdata[63:0];
	assign in_length = s_axis_tdata[127:64];
	assign in_kind   = s_axis_tdata[159:128];
	assign in_addr   = s_axis_tdata[191:160];
	assign in_size   = s_axis_tdata[223:192];
	assign in_end    = {1'b0, in_base} + {1'b0, in_length};

	// Region store
	logic [mrt_pkg::ADDR_W-1:0] base_mem [mrt_pkg::MAX_REGIONS];
	logic [mrt_pkg::END_W-1:0]  end_mem  [mrt_pkg::MAX_REGIONS];
	logic [mrt_pkg::ADDR_W-1:0] rd_base_s1;
	logic [mrt_pkg::END_W-1:0]  rd_end_s1;
	logic                       rd_v_s1;

	// Sequencer state
	logic [mrt_pkg::CNT_W-1:0]  count_q;
	logic [mrt_pkg::CNT_W-1:0]  issue_q;
	logic [mrt_pkg::QRY_W-1:0]  addr_q;
	logic [mrt_pkg::QEND_W-1:0] qend_q;
	logic                       fit_q;
	logic                       found_q;
	logic [mrt_pkg::QRY_W-1:0]  space_q;
	logic                       drop_q;
	logic                       m_valid_q;
	logic [mrt_pkg::OUT_DATA_W-1:0] m_data_q;

	logic accept;
	logic wr_en;
	logic rd_en;
	logic table_full;
	logic out_free;
	logic load_out;
	mrt_pkg::match_t match;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign table_full    = (count_q >= mrt_pkg::CNT_W'(mrt_pkg::MAX_REGIONS));
	assign wr_en         = accept && (s_axis_tuser == mrt_pkg::MODE_ADD)
			&& (in_kind == mrt_pkg::KIND_USABLE) && !table_full;
	assign rd_en         = (state_q == ST_SCAN) && (issue_q < count_q);
	assign out_free      = !m_valid_q || m_axis_tready;
	assign load_out      = (state_q == ST_EMIT) && out_free;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// Write new regions, read one entry per scan cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			base_mem[count_q[mrt_pkg::IDX_W-1:0]] <= in_base;
			end_mem[count_q[mrt_pkg::IDX_W-1:0]]  <= in_end;
		end
		if (rd_en) begin
			rd_base_s1 <= base_mem[issue_q[mrt_pkg::IDX_W-1:0]];
			rd_end_s1  <= end_mem[issue_q[mrt_pkg::IDX_W-1:0]];
		end
	end

	mrt_match u_match (
		.base       (rd_base_s1),
		.region_end (rd_end_s1),
		.addr       (addr_q),
		.qend       (qend_q),
		.result     (match)
	);

	// Sequencer, accumulators and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			issue_q   <= '0;
			rd_v_s1   <= 1'b0;
			fit_q     <= 1'b0;
			found_q   <= 1'b0;
			space_q   <= '0;
			drop_q    <= 1'b0;
			addr_q    <= '0;
			qend_q    <= '0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else begin
			// Drain the output register unless a new word is loaded
			if (m_valid_q && m_axis_tready && !load_out) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fit_q   <= 1'b0;
						found_q <= 1'b0;
						space_q <= '0;
						drop_q  <= 1'b0;
						if (s_axis_tuser == mrt_pkg::MODE_ADD) begin
							if (wr_en) begin
								count_q <= count_q + 1'b1;
							end
							if (in_kind == mrt_pkg::KIND_USABLE && table_full) begin
								drop_q <= 1'b1;
							end
							state_q <= ST_EMIT;
						end else begin
							addr_q  <= in_addr;
							qend_q  <= {1'b0, in_addr} + {1'b0, in_size};
							issue_q <= '0;
							state_q <= ST_SCAN;
						end
					end
				end

				ST_SCAN: begin
					// Advance the read pointer over the stored entries
					if (rd_en) begin
						issue_q <= issue_q + 1'b1;
						rd_v_s1 <= 1'b1;
					end else begin
						rd_v_s1 <= 1'b0;
					end
					// Keep the first hit of each kind
					if (rd_v_s1 && match.in_lo) begin
						if (match.fit) begin
							fit_q <= 1'b1;
						end
						if (!found_q && match.covers) begin
							found_q <= 1'b1;
							space_q <= match.space;
						end
					end
					if (!rd_en && !rd_v_s1) begin
						state_q <= ST_EMIT;
					end
				end

				ST_EMIT: begin
					// Hand the result to the output register once it is free
					if (load_out) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {{(mrt_pkg::OUT_DATA_W - mrt_pkg::QRY_W - 2){1'b0}},
								drop_q, space_q, fit_q};
						state_q   <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The entry count never passes the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= mrt_pkg::CNT_W'(mrt_pkg::MAX_REGIONS))
		else $error("entry count beyond table size");

	// Store writes happen only while idle, so they never overlap a scan
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_IDLE))
		else $error("store write outside idle");

	// The scan reads only written entries
	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (issue_q < count_q) && (state_q == ST_SCAN))
		else $error("scan read beyond entry count");

	// A result word is loaded only from the emit state
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result loaded outside emit");

	// A result never flags both a fit and a dropped add
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> !(m_data_q[0] && m_data_q[mrt_pkg::QRY_W + 1]))
		else $error("fit and drop flagged together");

endmodule

`default_nettype wire

/* test/memory_region_table_unit_tb.sv */
// Testbench for memory_region_table_unit: random and directed adds and queries, scoreboard check.
`timescale 1ns / 1ps

module memory_region_table_unit_tb;

	// One result word, as the block packs it
	typedef struct packed {
		bit        dropped;
		bit [31:0] space;
		bit        fits;
	} region_result_t;

	// Region table predictor with the queue of results still owed by the block
	class region_table_model;
		bit [63:0]      base_tab[mrt_pkg::MAX_REGIONS];
		bit [63:0]      len_tab[mrt_pkg::MAX_REGIONS];
		int unsigned    stored;
		int unsigned    errors;
		region_result_t owed_q[$];

		function new();
			stored = 0;
			errors = 0;
		endfunction

		function int unsigned pending();
			return owed_q.size();
		endfunction

		// Find the first region holding the range and the first one covering the address
		function region_result_t lookup(bit [31:0] addr, bit [31:0] size);
			bit [32:0]      q_end;
			bit [64:0]      r_end;
			bit [63:0]      rem;
			bit             got_fit;
			bit             got_space;
			region_result_t r;
			r = '0;
			got_fit = 1'b0;
			got_space = 1'b0;
			q_end = {1'b0, addr} + {1'b0, size};
			for (int i = 0; i < stored; i++) begin
				if (base_tab[i] <= {32'b0, addr}) begin
					r_end = {1'b0, base_tab[i]} + {1'b0, len_tab[i]};
					if (!got_fit && {32'b0, q_end} <= r_end) begin
						got_fit = 1'b1;
						r.fits = 1'b1;
					end
					if (!got_space && {33'b0, addr} <= r_end) begin
						got_space = 1'b1;
						rem = len_tab[i] - ({32'b0, addr} - base_tab[i]);
						r.space = (rem > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rem[31:0];
					end
				end
			end
			return r;
		endfunction

		// Take one accepted input word and queue the result it owes
		function void note_item(bit mode, bit [mrt_pkg::IN_DATA_W-1:0] data);
			region_result_t r;
			r = '0;
			if (mode == mrt_pkg::MODE_ADD) begin
				if (data[159:128] == mrt_pkg::KIND_USABLE) begin
					if (stored < mrt_pkg::MAX_REGIONS) begin
						base_tab[stored] = data[63:0];
						len_tab[stored] = data[127:64];
						stored++;
					end else begin
						r.dropped = 1'b1;
					end
				end
			end else begin
				r = lookup(data[191:160], data[223:192]);
			end
			owed_q.push_back(r);
		endfunction

		// Compare one result word with the oldest owed result
		function void check_word(bit [mrt_pkg::OUT_DATA_W-1:0] word);
			region_result_t want;
			if (owed_q.size() == 0) begin
				$error("result word %h with nothing owed", word);
				errors++;
				return;
			end
			want = owed_q.pop_front();
			if (word[0] !== want.fits) begin
				$error("range_fits: expected %0d, got %0d", want.fits, word[0]);
				errors++;
			end
			if (word[32:1] !== want.space) begin
				$error("space_left: expected %h, got %h", want.space, word[32:1]);
				errors++;
			end
			if (word[33] !== want.dropped) begin
				$error("add_dropped: expected %0d, got %0d", want.dropped, word[33]);
				errors++;
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic [mrt_pkg::IN_DATA_W-1:0]  s_axis_tdata;
	logic                           s_axis_tuser;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [mrt_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;

	region_table_model sb = new();
	bit                send_calm = 1'b0;
	bit                recv_calm = 1'b0;

	memory_region_table_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Present one word after a random gap and hold it until accepted
	task automatic send_item(input bit mode, input bit [mrt_pkg::IN_DATA_W-1:0] data);
		int unsigned gap;
		if ($urandom_range(0, 99) == 0) send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= data;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_item(mode, data);
	endtask

	task automatic add_region(input bit [63:0] base, input bit [63:0] len, input bit [31:0] kind);
		send_item(mrt_pkg::MODE_ADD, {$urandom, $urandom, kind, len, base});
	endtask

	task automatic query_range(input bit [31:0] addr, input bit [31:0] size);
		send_item(mrt_pkg::MODE_QUERY,
				{size, addr, $urandom, $urandom, $urandom, $urandom, $urandom});
	endtask

	// Drop the valid and hold off until every owed result has arrived
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Random add: mostly usable regions at low bases, lengths from tiny to huge
	task automatic random_add();
		bit [63:0] base;
		bit [63:0] len;
		bit [31:0] kind;
		case ($urandom_range(0, 4))
			0: base = {$urandom, $urandom};
			1: base = {32'b0, $urandom_range(0, 4095)};
			default: base = {32'b0, $urandom};
		endcase
		case ($urandom_range(0, 3))
			0: len = {32'b0, $urandom_range(0, 4096)};
			1: len = {32'b0, $urandom};
			2: len = {$urandom, $urandom};
			default: len = 64'hFFFF_FFFF_FFFF_FFFF - {32'b0, $urandom_range(0, 3)};
		endcase
		if ($urandom_range(0, 9) < 7)
			kind = mrt_pkg::KIND_USABLE;
		else
			kind = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4);
		add_region(base, len, kind);
	endtask

	// Random query: mostly aimed at a stored region, its start, its end and just past
	task automatic random_query();
		int unsigned idx;
		bit [63:0]   b;
		bit [63:0]   l;
		bit [63:0]   off;
		bit [63:0]   a;
		bit [63:0]   rem;
		bit [31:0]   qa;
		bit [31:0]   qs;
		qa = $urandom;
		qs = $urandom;
		if (sb.stored > 0 && $urandom_range(0, 9) < 7) begin
			idx = $urandom_range(0, sb.stored - 1);
			b = sb.base_tab[idx];
			l = sb.len_tab[idx];
			case ($urandom_range(0, 3))
				0: off = 64'd0;
				1: off = l;
				2: off = l + 64'd1;
				default: off = (l == 0) ? 64'd0 : {$urandom, $urandom} % l;
			endcase
			a = b + off;
			if (a[63:32] == 0 && a >= b) qa = a[31:0];
			case ($urandom_range(0, 2))
				0: qs = $urandom_range(0, 64);
				1: begin
					rem = l - off;
					qs = (off > l || rem > 64'hFFFF_FFFF) ? $urandom
						: rem[31:0] + $urandom_range(0, 1);
				end
				default: qs = $urandom;
			endcase
		end
		query_range(qa, qs);
	endtask

	// Accept results after a random stall and check each one
	initial begin
		int unsigned stall;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 99) == 0) recv_calm = !recv_calm;
			stall = recv_calm ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			sb.check_word(m_axis_tdata);
		end
	end

	// Main sequence
	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tuser <= mrt_pkg::MODE_ADD;
		s_axis_tdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: nothing fits, no space
		query_range(32'h0, 32'h0);
		query_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// Kinds other than usable are ignored
		add_region(64'h1000, 64'h1000, 32'd0);
		add_region(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd2);
		add_region(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		query_range(32'h1000, 32'h10);
		// One plain region: inside, inclusive end, straddling the end, below the base
		add_region(64'h1000, 64'h1000, mrt_pkg::KIND_USABLE);
		query_range(32'h1000, 32'h0);
		query_range(32'h1000, 32'h1000);
		query_range(32'h2000, 32'h0);
		query_range(32'h1FFF, 32'h2);
		query_range(32'h0FFF, 32'h1);
		// Zero-length region at zero, region wholly above the query space
		add_region(64'h0, 64'h0, mrt_pkg::KIND_USABLE);
		add_region(64'h1_0000_0000, 64'h5, mrt_pkg::KIND_USABLE);
		query_range(32'h0, 32'h0);
		query_range(32'h0, 32'h1);
		// Region end past 2^64: covers everything above its base, space saturates
		add_region(64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFFF, mrt_pkg::KIND_USABLE);
		add_region(64'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, mrt_pkg::KIND_USABLE);
		query_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		query_range(32'h8000_0000, 32'h0);
		query_range(32'h7FFF_FFFF, 32'h2);
		drain();

		// Random mix; the table fills part way through and adds start to drop
		for (int i = 0; i < 1500; i++) begin
			if (i == 700) drain();
			if ($urandom_range(0, 9) == 0)
				random_add();
			else
				random_query();
		end
		drain();
		repeat (40) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
